>>> design/assert_macros.svh
// Assertion macros used by the design top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> design/i2cram_pkg.sv
// Types and constants for the I2C register access master.
package i2cram_pkg;

  // Command codes carried in the action field.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT = 1'b1;

  // Configuration reset values.
  localparam logic [6:0] DEV_ADDR_RST  = 7'd54;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd250;

  // Header progress codes.
  localparam logic [1:0] HDR_DEV   = 2'd0;
  localparam logic [1:0] HDR_REG   = 2'd1;
  localparam logic [1:0] HDR_RDDEV = 2'd2;
  localparam logic [1:0] HDR_DATA  = 2'd3;

  // Bus phase, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_START = 7'b0000010,
    PH_SEND  = 7'b0000100,
    PH_WACK  = 7'b0001000,
    PH_RECV  = 7'b0010000,
    PH_MACK  = 7'b0100000,
    PH_STOP  = 7'b1000000
  } phase_e;

  // Transaction state carried from tick to tick.
  typedef struct packed {
    phase_e     phase;
    logic [1:0] tick;
    logic [2:0] bit_idx;
    logic [7:0] shift_byte;
    logic [7:0] bytes_left;
    logic [7:0] reg_hold;
    logic       read_mode;
    logic [7:0] ack_cnt;
    logic [1:0] hdr_stage;
  } state_t;

  // One input request.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_address;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } req_t;

  // One result item.
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       wr_taken;
    logic       busy;
    logic       done;
    logic       nack_error;
  } res_t;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0] dev_address;
    logic [7:0] ack_wait_limit;
  } cfg_t;

endpackage

>>> design/i2cram_step.sv
// Combinational tick logic: one request against the current state.
module i2cram_step (
  input  i2cram_pkg::state_t st_i,
  input  i2cram_pkg::req_t   req_i,
  input  i2cram_pkg::cfg_t   cfg_i,
  output i2cram_pkg::state_t st_o,
  output i2cram_pkg::res_t   res_o
);
  import i2cram_pkg::*;

  state_t s;
  res_t   r;

  always_comb begin
    s = st_i;
    r = '0;
    r.scl       = 1'b1;
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b1;
    r.busy      = 1'b1;

    // A command on an idle bus latches its header and starts at once.
    if ((s.phase == PH_IDLE) && ((req_i.action == ACT_READ) || (req_i.action == ACT_WRITE))) begin
      s.read_mode  = (req_i.action == ACT_READ);
      s.reg_hold   = req_i.reg_address;
      s.bytes_left = req_i.byte_count;
      s.hdr_stage  = HDR_DEV;
      s.ack_cnt    = 8'd0;
      s.shift_byte = 8'd0;
      s.phase      = PH_START;
      s.tick       = 2'd0;
      s.bit_idx    = 3'd0;
    end

    unique case (s.phase)
      PH_START: begin
        r.scl     = (s.tick < 2'd2);
        r.sda_out = (s.tick == 2'd0);
        if (s.tick >= 2'd2) begin
          s.shift_byte = {cfg_i.dev_address, (s.hdr_stage == HDR_RDDEV)};
          s.phase      = PH_SEND;
          s.tick       = 2'd0;
          s.bit_idx    = 3'd0;
        end else begin
          s.tick = s.tick + 2'd1;
        end
      end
      PH_SEND: begin
        r.sda_out = s.shift_byte[7];
        r.scl     = (s.tick == 2'd1);
        if (s.tick >= 2'd2) begin
          s.shift_byte = {s.shift_byte[6:0], 1'b0};
          s.tick       = 2'd0;
          if (s.bit_idx == 3'd7) begin
            s.phase   = PH_WACK;
            s.bit_idx = 3'd0;
            s.ack_cnt = 8'd0;
          end else begin
            s.bit_idx = s.bit_idx + 3'd1;
          end
        end else begin
          s.tick = s.tick + 2'd1;
        end
      end
      PH_WACK: begin
        r.sda_drive = 1'b0;
        r.scl       = (s.tick != 2'd0);
        if (s.tick < 2'd2) begin
          s.tick = s.tick + 2'd1;
        end else if (!req_i.sda_in) begin
          // Acknowledged: advance through the header, then the data bytes.
          s.tick    = 2'd0;
          s.bit_idx = 3'd0;
          if (s.hdr_stage == HDR_DEV) begin
            s.shift_byte = s.reg_hold;
            s.hdr_stage  = HDR_REG;
            s.phase      = PH_SEND;
          end else if ((s.hdr_stage == HDR_REG) && s.read_mode) begin
            s.hdr_stage = HDR_RDDEV;
            s.phase     = PH_START;
          end else if (s.hdr_stage == HDR_RDDEV) begin
            s.hdr_stage  = HDR_DATA;
            s.shift_byte = 8'd0;
            s.phase      = (s.bytes_left == 8'd0) ? PH_STOP : PH_RECV;
          end else if (s.bytes_left == 8'd0) begin
            s.phase = PH_STOP;
          end else begin
            r.wr_taken   = 1'b1;
            s.shift_byte = req_i.wr_data;
            s.bytes_left = s.bytes_left - 8'd1;
            s.hdr_stage  = HDR_DATA;
            s.phase      = PH_SEND;
          end
        end else if (s.ack_cnt >= cfg_i.ack_wait_limit) begin
          // Timed out waiting for the target: abort with a stop.
          r.nack_error = 1'b1;
          s.phase      = PH_STOP;
          s.tick       = 2'd0;
          s.bit_idx    = 3'd0;
        end else begin
          s.ack_cnt = s.ack_cnt + 8'd1;
        end
      end
      PH_RECV: begin
        r.sda_drive = 1'b0;
        r.scl       = (s.tick != 2'd0);
        if (s.tick == 2'd0) begin
          s.tick = 2'd1;
        end else begin
          s.shift_byte = {s.shift_byte[6:0], req_i.sda_in};
          s.tick       = 2'd0;
          if (s.bit_idx == 3'd7) begin
            r.rd_valid   = 1'b1;
            r.rd_data    = s.shift_byte;
            r.rd_last    = (s.bytes_left == 8'd1);
            s.bytes_left = s.bytes_left - 8'd1;
            s.phase      = PH_MACK;
            s.bit_idx    = 3'd0;
          end else begin
            s.bit_idx = s.bit_idx + 3'd1;
          end
        end
      end
      PH_MACK: begin
        // ACK every byte but the last, which gets a NACK.
        r.sda_out = (s.bytes_left == 8'd0);
        r.scl     = (s.tick == 2'd1);
        if (s.tick >= 2'd2) begin
          s.shift_byte = 8'd0;
          s.phase      = (s.bytes_left == 8'd0) ? PH_STOP : PH_RECV;
          s.tick       = 2'd0;
          s.bit_idx    = 3'd0;
        end else begin
          s.tick = s.tick + 2'd1;
        end
      end
      PH_STOP: begin
        r.scl     = (s.tick != 2'd0);
        r.sda_out = (s.tick != 2'd0);
        if (s.tick == 2'd0) begin
          s.tick = 2'd1;
        end else begin
          r.done      = 1'b1;
          s.phase     = PH_IDLE;
          s.tick      = 2'd0;
          s.bit_idx   = 3'd0;
          s.ack_cnt   = 8'd0;
          s.hdr_stage = HDR_DEV;
        end
      end
      default: begin
        // Idle tick: bus lines driven high.
        r.busy  = 1'b0;
        s.phase = PH_IDLE;
      end
    endcase
  end

  assign st_o  = s;
  assign res_o = r;

endmodule

>>> design/i2c_register_access_master_top.sv
// Top level of the I2C register access master: request, state and result registers.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o | action, reg_address, byte_count,
//           |           |                        | wr_data, sda_in
//   out     | output    | out_valid_o / out_stall_i | scl, sda_out, sda_drive, rd_data,
//           |           |                        | rd_valid, rd_last, wr_taken, busy_res,
//           |           |                        | done_res, nack_error
//
// One request is taken every clock cycle while in_stall_o is low; its result passes
// from the request register through the tick logic into the result register.
// Reset puts the bus state to idle and the configuration to its default values.
// While the output is stalled, the request register still takes one more request, then
// in_stall_o rises until the result register is freed.
`include "assert_macros.svh"

module i2c_register_access_master_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [i2cram_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                           cfg_data_i,
  // Request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           action_i,
  input  logic [7:0]                           reg_address_i,
  input  logic [7:0]                           byte_count_i,
  input  logic [7:0]                           wr_data_i,
  input  logic                                 sda_in_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 scl_o,
  output logic                                 sda_out_o,
  output logic                                 sda_drive_o,
  output logic [7:0]                           rd_data_o,
  output logic                                 rd_valid_o,
  output logic                                 rd_last_o,
  output logic                                 wr_taken_o,
  output logic                                 busy_res_o,
  output logic                                 done_res_o,
  output logic                                 nack_error_o
);
  import i2cram_pkg::*;

  cfg_t   cfg_q;
  req_t   req_q;
  logic   in_valid_q;
  state_t st_q, st_d;
  res_t   res_q, res_d;
  logic   out_valid_q;
  logic   advance;
  logic   in_accept;
  logic   load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_address    <= DEV_ADDR_RST;
      cfg_q.ack_wait_limit <= ACK_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DEV_ADDR) begin
        cfg_q.dev_address <= cfg_data_i[6:0];
      end
      if (cfg_index_i == CFG_ACK_LIMIT) begin
        cfg_q.ack_wait_limit <= cfg_data_i;
      end
    end
  end

  // Handshake: the result register frees when empty or when its result is taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign load       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.action      <= action_i;
      req_q.reg_address <= reg_address_i;
      req_q.byte_count  <= byte_count_i;
      req_q.wr_data     <= wr_data_i;
      req_q.sda_in      <= sda_in_i;
    end
  end

  // Tick logic.
  i2cram_step u_step (
    .st_i  (st_q),
    .req_i (req_q),
    .cfg_i (cfg_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // Transaction state, updated once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, tick: 2'd0, bit_idx: 3'd0, shift_byte: 8'd0,
                bytes_left: 8'd0, reg_hold: 8'd0, read_mode: 1'b0, ack_cnt: 8'd0,
                hdr_stage: HDR_DEV};
    end else if (load) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_o        = res_q.scl;
  assign sda_out_o    = res_q.sda_out;
  assign sda_drive_o  = res_q.sda_drive;
  assign rd_data_o    = res_q.rd_data;
  assign rd_valid_o   = res_q.rd_valid;
  assign rd_last_o    = res_q.rd_last;
  assign wr_taken_o   = res_q.wr_taken;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign nack_error_o = res_q.nack_error;

  // A completed stop leaves the bus idle.
  `ASSERT_CLK(a_done_idle, clk_i, rst_ni, (load && res_d.done) |=> (st_q.phase == PH_IDLE), "done without return to idle")
  // An idle tick never leaves the idle phase.
  `ASSERT_CLK(a_notbusy_idle, clk_i, rst_ni, (load && !res_d.busy) |=> (st_q.phase == PH_IDLE), "idle tick changed phase")
  // An acknowledge timeout always heads to stop.
  `ASSERT_CLK(a_nack_stop, clk_i, rst_ni, (load && res_d.nack_error) |=> (st_q.phase == PH_STOP), "timeout without stop")
  // Write data is only taken on the write path.
  `ASSERT_NEVER(a_wr_in_read, clk_i, rst_ni, load && res_d.wr_taken && st_q.read_mode, "write data taken during read")

endmodule

>>> tb/sv/i2cram_tb_pkg.sv
// Bus tick predictor and result scoreboard for the I2C register access master bench.
`timescale 1ns / 1ps
package i2cram_tb_pkg;
  import i2cram_pkg::*;

  class bus_tick_scoreboard;
    // Configuration as last written.
    logic [6:0]  dev_addr;
    logic [7:0]  ack_limit;
    // Predicted bus state.
    phase_e      phase;
    logic [1:0]  tick;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  bytes_left;
    logic [7:0]  reg_hold;
    logic        read_mode;
    logic [7:0]  ack_cnt;
    logic [1:0]  hdr;
    // Bus levels and flags still owed by the block, oldest first.
    res_t        expected_ticks[$];
    int unsigned fail_cnt;

    function new();
      dev_addr   = DEV_ADDR_RST;
      ack_limit  = ACK_LIMIT_RST;
      phase      = PH_IDLE;
      tick       = '0;
      bit_idx    = '0;
      shreg      = '0;
      bytes_left = '0;
      reg_hold   = '0;
      read_mode  = 1'b0;
      ack_cnt    = '0;
      hdr        = HDR_DEV;
      fail_cnt   = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == CFG_DEV_ADDR) begin
        dev_addr = value[6:0];
      end else if (idx == CFG_ACK_LIMIT) begin
        ack_limit = value;
      end
    endfunction

    function void enter(phase_e ph);
      phase   = ph;
      tick    = '0;
      bit_idx = '0;
    endfunction

    // Advance the bus by one accepted request and queue the levels it produces.
    function void take_request(req_t r);
      res_t o;
      o           = '0;
      o.scl       = 1'b1;
      o.sda_out   = 1'b1;
      o.sda_drive = 1'b1;
      o.busy      = 1'b1;

      // A command only starts a transaction from idle; the same tick is the first START tick.
      if (phase == PH_IDLE && (r.action == ACT_READ || r.action == ACT_WRITE)) begin
        read_mode  = (r.action == ACT_READ);
        reg_hold   = r.reg_address;
        bytes_left = r.byte_count;
        hdr        = HDR_DEV;
        ack_cnt    = '0;
        shreg      = '0;
        enter(PH_START);
      end

      case (phase)
        PH_START: begin
          o.scl     = (tick < 2'd2);
          o.sda_out = (tick == 2'd0);
          if (tick >= 2'd2) begin
            shreg = {dev_addr, (hdr == HDR_RDDEV) ? 1'b1 : 1'b0};
            enter(PH_SEND);
          end else begin
            tick = tick + 2'd1;
          end
        end
        PH_SEND: begin
          o.sda_out = shreg[7];
          o.scl     = (tick == 2'd1);
          if (tick >= 2'd2) begin
            shreg = shreg << 1;
            if (bit_idx >= 3'd7) begin
              enter(PH_WACK);
              ack_cnt = '0;
            end else begin
              bit_idx = bit_idx + 3'd1;
              tick    = '0;
            end
          end else begin
            tick = tick + 2'd1;
          end
        end
        PH_WACK: begin
          o.sda_drive = 1'b0;
          o.scl       = (tick != 2'd0);
          if (tick < 2'd2) begin
            tick = tick + 2'd1;
          end else if (!r.sda_in) begin
            // Acknowledged: move on to the next header byte, data byte or stop.
            if (hdr == HDR_DEV) begin
              shreg = reg_hold;
              hdr   = HDR_REG;
              enter(PH_SEND);
            end else if (hdr == HDR_REG && read_mode) begin
              hdr = HDR_RDDEV;
              enter(PH_START);
            end else if (hdr == HDR_RDDEV) begin
              hdr   = HDR_DATA;
              shreg = '0;
              enter(bytes_left == 8'd0 ? PH_STOP : PH_RECV);
            end else if (bytes_left == 8'd0) begin
              enter(PH_STOP);
            end else begin
              shreg      = r.wr_data;
              bytes_left = bytes_left - 8'd1;
              hdr        = HDR_DATA;
              o.wr_taken = 1'b1;
              enter(PH_SEND);
            end
          end else if (ack_cnt >= ack_limit) begin
            o.nack_error = 1'b1;
            enter(PH_STOP);
          end else begin
            ack_cnt = ack_cnt + 8'd1;
          end
        end
        PH_RECV: begin
          o.sda_drive = 1'b0;
          o.scl       = (tick != 2'd0);
          if (tick == 2'd0) begin
            tick = 2'd1;
          end else begin
            shreg = {shreg[6:0], r.sda_in};
            if (bit_idx >= 3'd7) begin
              o.rd_valid = 1'b1;
              o.rd_data  = shreg;
              o.rd_last  = (bytes_left == 8'd1);
              bytes_left = bytes_left - 8'd1;
              enter(PH_MACK);
            end else begin
              bit_idx = bit_idx + 3'd1;
              tick    = '0;
            end
          end
        end
        PH_MACK: begin
          // The last byte is answered with a NACK, all others with an ACK.
          o.sda_out = (bytes_left == 8'd0);
          o.scl     = (tick == 2'd1);
          if (tick >= 2'd2) begin
            shreg = '0;
            enter(bytes_left == 8'd0 ? PH_STOP : PH_RECV);
          end else begin
            tick = tick + 2'd1;
          end
        end
        PH_STOP: begin
          o.scl     = (tick != 2'd0);
          o.sda_out = (tick != 2'd0);
          if (tick == 2'd0) begin
            tick = 2'd1;
          end else begin
            o.done  = 1'b1;
            enter(PH_IDLE);
            ack_cnt = '0;
            hdr     = HDR_DEV;
          end
        end
        default: begin
          o.busy = 1'b0;
        end
      endcase

      expected_ticks.push_back(o);
    endfunction

    function string show(res_t r);
      return $sformatf({"scl=%b sda=%b drv=%b rd_data=%h rd_valid=%b rd_last=%b ",
                        "wr_taken=%b busy=%b done=%b nack=%b"},
                       r.scl, r.sda_out, r.sda_drive, r.rd_data, r.rd_valid, r.rd_last,
                       r.wr_taken, r.busy, r.done, r.nack_error);
    endfunction

    function void note_failure(string msg);
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // Compare one accepted result with the oldest prediction, field by field.
    function void check_result(res_t got);
      res_t  want;
      string diffs;
      if (expected_ticks.size() == 0) begin
        note_failure($sformatf("result with no request pending: %s", show(got)));
        return;
      end
      want  = expected_ticks.pop_front();
      diffs = "";
      if (got.scl !== want.scl) diffs = {diffs, " scl"};
      if (got.sda_out !== want.sda_out) diffs = {diffs, " sda_out"};
      if (got.sda_drive !== want.sda_drive) diffs = {diffs, " sda_drive"};
      if (got.rd_data !== want.rd_data) diffs = {diffs, " rd_data"};
      if (got.rd_valid !== want.rd_valid) diffs = {diffs, " rd_valid"};
      if (got.rd_last !== want.rd_last) diffs = {diffs, " rd_last"};
      if (got.wr_taken !== want.wr_taken) diffs = {diffs, " wr_taken"};
      if (got.busy !== want.busy) diffs = {diffs, " busy_res"};
      if (got.done !== want.done) diffs = {diffs, " done_res"};
      if (got.nack_error !== want.nack_error) diffs = {diffs, " nack_error"};
      if (diffs != "") begin
        note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                               diffs, show(want), show(got)));
      end
    endfunction
  endclass

endpackage

>>> tb/sv/i2c_register_access_master_top_tb.sv
// Self-checking bench for the I2C register access master top level.
`timescale 1ns / 1ps
module i2c_register_access_master_top_tb;
  import i2cram_pkg::*;
  import i2cram_tb_pkg::*;

  // Action code 3 is not a command; the block treats it as a plain tick.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  // Far above the slowest correct run, including the long receiver hold-offs.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEV_ADDR;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = ACT_TICK;
  logic [7:0] reg_address = '0;
  logic [7:0] byte_count = '0;
  logic [7:0] wr_data = '0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic [7:0] rd_data;
  logic       rd_valid;
  logic       rd_last;
  logic       wr_taken;
  logic       busy_res;
  logic       done_res;
  logic       nack_error;

  bus_tick_scoreboard sb;
  int unsigned cycle_cnt = 0;
  int unsigned tx_quiet = 0;
  int unsigned rx_quiet = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_off_req = 1'b0;
  bit          refuse_ack = 1'b0;
  bit          force_refuse = 1'b0;

  i2c_register_access_master_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .reg_address_i (reg_address),
    .byte_count_i  (byte_count),
    .wr_data_i     (wr_data),
    .sda_in_i      (sda_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .scl_o         (scl),
    .sda_out_o     (sda_out),
    .sda_drive_o   (sda_drive),
    .rd_data_o     (rd_data),
    .rd_valid_o    (rd_valid),
    .rd_last_o     (rd_last),
    .wr_taken_o    (wr_taken),
    .busy_res_o    (busy_res),
    .done_res_o    (done_res),
    .nack_error_o  (nack_error)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Idle length: mostly none or short, a few long, with occasional quiet stretches.
  function automatic int unsigned pause_len(ref int unsigned quiet_left);
    int unsigned roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 999);
    if (roll < 15) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 600) return 0;
    if (roll < 900) return $urandom_range(1, 3);
    if (roll < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly short transfers, now and then a long one that an ACK refusal usually cuts short.
  function automatic logic [7:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 8'($urandom_range(0, 2));
    if (roll < 85) return 8'($urandom_range(3, 8));
    if (roll < 97) return 8'($urandom_range(9, 24));
    return 8'($urandom_range(128, 255));
  endfunction

  // Choose the next request from the predicted bus state, so that most sequences are
  // well formed: commands from idle, ticks while busy, ACKs mostly given.
  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    r.action      = ACT_TICK;
    r.reg_address = 8'($urandom);
    r.byte_count  = 8'($urandom);
    r.wr_data     = 8'($urandom);
    r.sda_in      = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (sb.phase == PH_IDLE) begin
      if (roll < 70) begin
        r.action     = (roll < 35) ? ACT_READ : ACT_WRITE;
        r.byte_count = pick_count();
      end else if (roll < 80) begin
        r.action = ACT_SPARE;
      end
    end else begin
      // Commands while busy are ignored by the block.
      if (roll < 3) begin
        r.action = ACT_READ;
      end else if (roll < 6) begin
        r.action = ACT_WRITE;
      end else if (roll < 9) begin
        r.action = ACT_SPARE;
      end
      if (sb.phase == PH_WACK) begin
        // Decide once per ACK wait whether the target refuses until the timeout.
        if (sb.tick == 2'd0) begin
          refuse_ack = force_refuse ||
                       ($urandom_range(0, 99) < ((sb.bytes_left > 8'd32) ? 85 : 4));
        end
        r.sda_in = refuse_ack || ($urandom_range(0, 99) < 12);
      end
    end
    return r;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input req_t r);
    in_valid    <= 1'b1;
    action      <= r.action;
    reg_address <= r.reg_address;
    byte_count  <= r.byte_count;
    wr_data     <= r.wr_data;
    sda_in      <= r.sda_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_request(r);
  endtask

  task automatic sender_pause();
    int unsigned n;
    n = pause_len(tx_quiet);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic finish_transaction();
    while (sb.phase != PH_IDLE) begin
      sender_pause();
      send_request(pick_request());
    end
  endtask

  task automatic run_command(input logic [1:0] act, input logic [7:0] reg_addr,
                             input logic [7:0] count, input bit refuse);
    req_t r;
    r = '{action: act, reg_address: reg_addr, byte_count: count,
          wr_data: 8'($urandom), sda_in: 1'($urandom)};
    force_refuse = refuse;
    sender_pause();
    send_request(r);
    finish_transaction();
    force_refuse = 1'b0;
  endtask

  task automatic run_traffic(input int unsigned n_items);
    repeat (n_items) begin
      sender_pause();
      send_request(pick_request());
    end
    finish_transaction();
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_ticks.size() != 0) @(posedge clk);
  endtask

  // Write both registers; bit 7 of the address write is noise that the block drops.
  task automatic write_config(input logic [6:0] dev, input logic [7:0] limit);
    logic [7:0] dev_word;
    dev_word = {1'($urandom), dev};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEV_ADDR;
    cfg_data  <= dev_word;
    @(posedge clk);
    cfg_index <= CFG_ACK_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(CFG_DEV_ADDR, dev_word);
    sb.set_config(CFG_ACK_LIMIT, limit);
  endtask

  task automatic traffic_phase(input logic [6:0] dev, input logic [7:0] limit,
                               input int unsigned n_items, input bit pressure);
    write_config(dev, limit);
    if (pressure) hold_off_req = 1'b1;
    run_traffic(n_items);
    drain();
  endtask

  // Result side: check every accepted result and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({scl, sda_out, sda_drive, rd_data, rd_valid, rd_last,
                       wr_taken, busy_res, done_res, nack_error});
    end
    if (hold_off_req) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) stall_left = pause_len(rx_quiet);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Main sequence: directed transactions, then random traffic under several settings.
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks with all-low and all-high fields, the spare action among them.
    send_request('{action: ACT_TICK, reg_address: 8'h00, byte_count: 8'h00,
                   wr_data: 8'h00, sda_in: 1'b0});
    send_request('{action: ACT_SPARE, reg_address: 8'hFF, byte_count: 8'hFF,
                   wr_data: 8'hFF, sda_in: 1'b1});
    // Zero-length write and read, short transfers, and a device ACK timeout.
    run_command(ACT_WRITE, 8'h00, 8'd0, 1'b0);
    run_command(ACT_READ, 8'hFF, 8'd0, 1'b0);
    run_command(ACT_WRITE, 8'hA5, 8'd2, 1'b0);
    run_command(ACT_READ, 8'h3C, 8'd3, 1'b0);
    run_command(ACT_WRITE, 8'h81, 8'd255, 1'b1);
    drain();

    traffic_phase(7'h7F, 8'd0, 120, 1'b0);
    traffic_phase(7'h00, 8'd255, 120, 1'b1);
    traffic_phase(7'($urandom), 8'd1, 120, 1'b0);
    traffic_phase(7'($urandom), 8'($urandom_range(2, 12)), 120, 1'b1);
    traffic_phase(7'h2A, ACK_LIMIT_RST, 120, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.fail_cnt == 0 && sb.expected_ticks.size() == 0) begin
      $display("[i2c_register_access_master_top] OK");
    end else begin
      $display("[i2c_register_access_master_top] ERROR");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[i2c_register_access_master_top] ERROR");
    $finish;
  end

endmodule
